>>> design/pts_pkg.sv
// pts_pkg: shared types, token class codes and keyword/operator tables
// for the pascal token scanner. No dependencies.
package pts_pkg;

	localparam int MaxWord = 14;
	localparam int LenW = $clog2(MaxWord + 1);
	localparam int KwCount = 54;
	localparam int KwChars = 15;
	localparam int OpCount = 26;

	localparam logic [6:0] CLS_EOF = 7'd0;
	localparam logic [6:0] CLS_INT = 7'd1;
	localparam logic [6:0] CLS_REAL = 7'd2;
	localparam logic [6:0] CLS_ID = 7'd3;
	localparam logic [6:0] CLS_KW0 = 7'd4;
	localparam logic [6:0] CLS_OP0 = 7'd58;

	localparam logic [2:0] MODE_IDLE = 3'd0;
	localparam logic [2:0] MODE_WORD = 3'd1;
	localparam logic [2:0] MODE_INT = 3'd2;
	localparam logic [2:0] MODE_REAL = 3'd3;
	localparam logic [2:0] MODE_SPECIAL = 3'd4;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_END = 1'b1;

	typedef logic [MaxWord-1:0][7:0] word_t;

	// up to two results from one request
	typedef struct packed {
		logic [1:0] count;
		logic [6:0] cls0;
		logic [6:0] cls1;
	} result_t;

	typedef logic [KwChars*8-1:0] kw_str_t;

	// keyword spellings, first character in the low byte, zero padded
	function automatic kw_str_t kw_entry(input logic [5:0] idx);
		kw_str_t s;
		s = '0;
		case (idx)
			6'd0: s = "dna";
			6'd1: s = "yarra";
			6'd2: s = "msa";
			6'd3: s = "nigeb";
			6'd4: s = "kaerb";
			6'd5: s = "esac";
			6'd6: s = "tsnoc";
			6'd7: s = "rotcurtsnoc";
			6'd8: s = "eunitnoc";
			6'd9: s = "rotcurtsed";
			6'd10: s = "vid";
			6'd11: s = "od";
			6'd12: s = "otnwod";
			6'd13: s = "esle";
			6'd14: s = "dne";
			6'd15: s = "eslaf";
			6'd16: s = "elif";
			6'd17: s = "rof";
			6'd18: s = "noitcnuf";
			6'd19: s = "otog";
			6'd20: s = "fi";
			6'd21: s = "noitatnemelpmi";
			6'd22: s = "ni";
			6'd23: s = "enilni";
			6'd24: s = "ecafretni";
			6'd25: s = "lebal";
			6'd26: s = "dom";
			6'd27: s = "lin";
			6'd28: s = "ton";
			6'd29: s = "tcejbo";
			6'd30: s = "fo";
			6'd31: s = "no";
			6'd32: s = "rotarepo";
			6'd33: s = "ro";
			6'd34: s = "dekcap";
			6'd35: s = "erudecorp";
			6'd36: s = "margorp";
			6'd37: s = "drocer";
			6'd38: s = "taeper";
			6'd39: s = "tes";
			6'd40: s = "lhs";
			6'd41: s = "rhs";
			6'd42: s = "gnirts";
			6'd43: s = "neht";
			6'd44: s = "ot";
			6'd45: s = "eurt";
			6'd46: s = "epyt";
			6'd47: s = "tinu";
			6'd48: s = "litnu";
			6'd49: s = "sesu";
			6'd50: s = "rav";
			6'd51: s = "elihw";
			6'd52: s = "htiw";
			6'd53: s = "rox";
			default: s = '0;
		endcase
		return s;
	endfunction

	function automatic logic is_special(input logic [7:0] c);
		return c == "+" || c == "-" || c == "*" || c == "/" || c == ":" || c == "=" ||
			c == "<" || c == ">" || c == "^" || c == ";" || c == "," || c == "(" ||
			c == ")" || c == "[" || c == "]" || c == "{" || c == "}";
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_num(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == 8'h20 || c == 8'h09 || c == 8'h0a;
	endfunction

	function automatic logic [7:0] lower(input logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	// operator class of a pair; second of zero is a lone special
	function automatic logic [6:0] op_class(input logic [7:0] a, input logic [7:0] b);
		logic [15:0] p;
		logic [6:0] r;
		p = {a, b};
		r = CLS_ID;
		case (p)
			{"+", 8'h0}: r = CLS_OP0 + 7'd0;
			{"-", 8'h0}: r = CLS_OP0 + 7'd1;
			{"*", 8'h0}: r = CLS_OP0 + 7'd2;
			{"/", 8'h0}: r = CLS_OP0 + 7'd3;
			{":", "="}: r = CLS_OP0 + 7'd4;
			{"=", 8'h0}: r = CLS_OP0 + 7'd5;
			{"<", ">"}: r = CLS_OP0 + 7'd6;
			{"<", "="}: r = CLS_OP0 + 7'd7;
			{">", "="}: r = CLS_OP0 + 7'd8;
			{"<", 8'h0}: r = CLS_OP0 + 7'd9;
			{">", 8'h0}: r = CLS_OP0 + 7'd10;
			{"+", "="}: r = CLS_OP0 + 7'd11;
			{"-", "="}: r = CLS_OP0 + 7'd12;
			{"*", "="}: r = CLS_OP0 + 7'd13;
			{"/", "="}: r = CLS_OP0 + 7'd14;
			{"^", 8'h0}: r = CLS_OP0 + 7'd15;
			{";", 8'h0}: r = CLS_OP0 + 7'd16;
			{",", 8'h0}: r = CLS_OP0 + 7'd17;
			{"(", 8'h0}: r = CLS_OP0 + 7'd18;
			{")", 8'h0}: r = CLS_OP0 + 7'd19;
			{"[", 8'h0}: r = CLS_OP0 + 7'd20;
			{"]", 8'h0}: r = CLS_OP0 + 7'd21;
			{"{", 8'h0}: r = CLS_OP0 + 7'd22;
			{"}", 8'h0}: r = CLS_OP0 + 7'd23;
			{"(", "*"}: r = CLS_OP0 + 7'd24;
			{"*", ")"}: r = CLS_OP0 + 7'd25;
			default: r = CLS_ID;
		endcase
		return r;
	endfunction

endpackage

>>> design/pascal_token_scanner.sv
// pascal_token_scanner: top level, scan state and token decisions
// depends on pts_pkg, pts_kw_match, pts_out_queue
//
// channel | signals                                   | role
// in      | valid, ready, command, text_byte          | one byte or end request
// out     | out_valid, out_ready, token_class, last   | zero to two classes per request
//
// One request per cycle while ready is high; each byte is resolved in the
// cycle it is accepted and its classes land in a two-entry output register.
// A request that yields two classes keeps ready low until its second class leaves.
// ready is low only while the output register still holds an unsent class
// that will not leave this cycle. Reset clears the scan mode and the queue.
module pascal_token_scanner (
	input logic clk,
	input logic arst_n,
	input logic valid,
	output logic ready,
	input logic command,
	input logic [7:0] text_byte,
	output logic out_valid,
	input logic out_ready,
	output logic [6:0] token_class,
	output logic last
);
	logic [2:0] mode_q;
	logic [pts_pkg::MaxWord-1:0][7:0] buf_q;
	logic [pts_pkg::LenW-1:0] len_q;
	logic ovf_q;
	logic [7:0] first_q;
	logic [6:0] word_cls;
	logic acc;
	pts_pkg::result_t res;
	logic [2:0] mode_d;
	logic start;
	logic [6:0] pend;
	logic has_pend;

	pts_kw_match u_kw (
		.word(buf_q), .length(len_q), .overflow(ovf_q), .cls(word_cls)
	);

	pts_out_queue u_q (
		.clk(clk), .arst_n(arst_n), .load(acc), .res(res), .empty_next(ready),
		.valid(out_valid), .ready(out_ready), .token_class(token_class), .last(last)
	);

	assign acc = valid && ready;

	// pending token class when it ends
	always_comb begin
		has_pend = 1'b1;
		pend = pts_pkg::CLS_ID;
		unique case (mode_q)
			pts_pkg::MODE_WORD: pend = word_cls;
			pts_pkg::MODE_INT: pend = pts_pkg::CLS_INT;
			pts_pkg::MODE_REAL: pend = pts_pkg::CLS_REAL;
			pts_pkg::MODE_SPECIAL: pend = pts_pkg::op_class(first_q, 8'h0);
			default: has_pend = 1'b0;
		endcase
	end

	// next mode and results
	always_comb begin
		res = '0;
		mode_d = mode_q;
		start = 1'b0;
		if (command == pts_pkg::CMD_END) begin
			mode_d = pts_pkg::MODE_IDLE;
			if (has_pend) begin
				res.count = 2'd2; res.cls0 = pend; res.cls1 = pts_pkg::CLS_EOF;
			end else begin
				res.count = 2'd1; res.cls0 = pts_pkg::CLS_EOF;
			end
		end else begin
			unique case (mode_q)
				pts_pkg::MODE_WORD: start = !(pts_pkg::is_alpha(text_byte) ||
					pts_pkg::is_num(text_byte));
				pts_pkg::MODE_INT: begin
					if (text_byte == ".") mode_d = pts_pkg::MODE_REAL;
					else start = !pts_pkg::is_num(text_byte);
				end
				pts_pkg::MODE_REAL: start = !pts_pkg::is_num(text_byte);
				pts_pkg::MODE_SPECIAL: begin
					if (pts_pkg::is_special(text_byte)) begin
						mode_d = pts_pkg::MODE_IDLE;
						res.count = 2'd1;
						res.cls0 = pts_pkg::op_class(first_q, text_byte);
					end else start = 1'b1;
				end
				default: start = 1'b1;
			endcase
			if (start) begin
				if (has_pend) begin
					res.count = 2'd1; res.cls0 = pend;
				end
				mode_d = pts_pkg::MODE_IDLE;
				if (pts_pkg::is_alpha(text_byte)) mode_d = pts_pkg::MODE_WORD;
				else if (pts_pkg::is_num(text_byte)) mode_d = pts_pkg::MODE_INT;
				else if (pts_pkg::is_special(text_byte)) mode_d = pts_pkg::MODE_SPECIAL;
				else if (!pts_pkg::is_space(text_byte)) begin
					if (has_pend) begin
						res.count = 2'd2; res.cls1 = pts_pkg::CLS_ID;
					end else begin
						res.count = 2'd1; res.cls0 = pts_pkg::CLS_ID;
					end
				end
			end
		end
	end

	// scan control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= pts_pkg::MODE_IDLE;
			len_q <= '0;
			ovf_q <= 1'b0;
			first_q <= 8'h0;
		end else if (acc) begin
			mode_q <= mode_d;
			if (command == pts_pkg::CMD_END) begin
				len_q <= '0;
				ovf_q <= 1'b0;
			end else if (start && mode_d == pts_pkg::MODE_WORD) begin
				len_q <= pts_pkg::LenW'(1);
				ovf_q <= 1'b0;
			end else if (!start && mode_q == pts_pkg::MODE_WORD) begin
				if (len_q < pts_pkg::LenW'(pts_pkg::MaxWord)) len_q <= len_q + 1'b1;
				else ovf_q <= 1'b1;
			end
			if (start && mode_d == pts_pkg::MODE_SPECIAL) first_q <= text_byte;
		end
	end

	// word buffer
	always_ff @(posedge clk) begin
		if (acc && command == pts_pkg::CMD_BYTE) begin
			if (start && mode_d == pts_pkg::MODE_WORD) begin
				buf_q[0] <= pts_pkg::lower(text_byte);
			end else if (!start && mode_q == pts_pkg::MODE_WORD &&
					len_q < pts_pkg::LenW'(pts_pkg::MaxWord)) begin
				buf_q[len_q] <= pts_pkg::lower(text_byte);
			end
		end
	end
endmodule

>>> design/pts_kw_match.sv
// pts_kw_match: parallel compare of the word buffer against all keywords
// depends on pts_pkg
module pts_kw_match (
	input logic [pts_pkg::MaxWord-1:0][7:0] word,
	input logic [pts_pkg::LenW-1:0] length,
	input logic overflow,
	output logic [6:0] cls
);
	logic [pts_pkg::KwCount-1:0] hit;

	// one comparator per keyword, independent
	always_comb begin
		for (int i = 0; i < pts_pkg::KwCount; i++) begin
			pts_pkg::kw_str_t s;
			logic same;
			s = pts_pkg::kw_entry(6'(i));
			same = 1'b1;
			for (int k = 0; k < pts_pkg::KwChars; k++) begin
				if (k < int'(length)) begin
					if (k >= pts_pkg::MaxWord || s[k*8 +: 8] != word[k]) same = 1'b0;
				end else if (k == int'(length)) begin
					if (s[k*8 +: 8] != 8'h0) same = 1'b0;
				end
			end
			hit[i] = same;
		end
	end

	// first hit wins; keywords are distinct so at most one hits
	always_comb begin
		cls = pts_pkg::CLS_ID;
		if (!overflow && length != '0) begin
			for (int i = pts_pkg::KwCount - 1; i >= 0; i--) begin
				if (hit[i]) cls = pts_pkg::CLS_KW0 + 7'(i);
			end
		end
	end
endmodule

>>> design/pts_out_queue.sv
// pts_out_queue: holds up to two result classes and hands them out one by one
// depends on pts_pkg
module pts_out_queue (
	input logic clk,
	input logic arst_n,
	input logic load,
	input pts_pkg::result_t res,
	output logic empty_next,
	output logic valid,
	input logic ready,
	output logic [6:0] token_class,
	output logic last
);
	logic [1:0] cnt_q;
	logic [6:0] c0_q, c1_q;
	logic pop;

	assign valid = cnt_q != 2'd0;
	assign pop = valid && ready;
	assign token_class = c0_q;
	assign last = cnt_q == 2'd1;
	// free after this cycle if last entry leaves or nothing held
	assign empty_next = cnt_q == 2'd0 || (cnt_q == 2'd1 && pop);

	// count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= res.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			c0_q <= res.cls0;
			c1_q <= res.cls1;
		end else if (pop) begin
			c0_q <= c1_q;
		end
	end
endmodule

>>> tb/pascal_token_scanner_tb.sv
// pascal_token_scanner_tb: self-checking bench for the pascal token scanner
// depends on pts_pkg and pascal_token_scanner; scoreboard predicts each token class
module pascal_token_scanner_tb;

	typedef struct {
		logic cmd;
		logic [7:0] ch;
	} scan_req_t;

	typedef struct {
		logic [6:0] cls;
		logic lst;
	} token_t;

	logic clk;
	logic arst_n;
	logic valid;
	logic ready;
	logic command;
	logic [7:0] text_byte;
	logic out_valid;
	logic out_ready;
	logic [6:0] token_class;
	logic last;

	scan_req_t pending_reqs[$];
	token_t expected_tokens[$];
	int error_count;
	bit stim_done;
	int hold_off;

	// predictor state
	logic [2:0] p_mode;
	logic [7:0] p_buf[pts_pkg::MaxWord];
	int p_len;
	logic p_ovf;
	logic [7:0] p_first;
	token_t new_tokens[$];

	string keywords[pts_pkg::KwCount] = '{
		"and", "array", "asm", "begin", "break", "case", "const", "constructor",
		"continue", "destructor", "div", "do", "downto", "else", "end", "false",
		"file", "for", "function", "goto", "if", "implementation", "in", "inline",
		"interface", "label", "mod", "nil", "not", "object", "of", "on",
		"operator", "or", "packed", "procedure", "program", "record", "repeat",
		"set", "shl", "shr", "string", "then", "to", "true", "type", "unit",
		"until", "uses", "var", "while", "with", "xor"};
	string operators[pts_pkg::OpCount] = '{
		"+", "-", "*", "/", ":=", "=", "<>", "<=", ">=", "<", ">", "+=", "-=",
		"*=", "/=", "^", ";", ",", "(", ")", "[", "]", "{", "}", "(*", "*)"};
	string specials = "+-*/:=<>^;,()[]{}";

	pascal_token_scanner u_top (
		.clk(clk), .arst_n(arst_n), .valid(valid), .ready(ready),
		.command(command), .text_byte(text_byte), .out_valid(out_valid),
		.out_ready(out_ready), .token_class(token_class), .last(last)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic bit b_alpha(logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
	endfunction
	function automatic bit b_num(logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction
	function automatic bit b_space(logic [7:0] c);
		return c == 8'h20 || c == 8'h09 || c == 8'h0a;
	endfunction
	function automatic bit b_special(logic [7:0] c);
		for (int i = 0; i < specials.len(); i++)
			if (specials[i] == c) return 1;
		return 0;
	endfunction
	function automatic logic [7:0] to_lower(logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
	endfunction

	function automatic logic [6:0] classify_word();
		bit same;
		if (p_ovf || p_len == 0 || p_len >= pts_pkg::KwChars) return pts_pkg::CLS_ID;
		for (int i = 0; i < pts_pkg::KwCount; i++) begin
			same = keywords[i].len() == p_len;
			for (int k = 0; same && k < p_len; k++)
				if (keywords[i][k] != p_buf[k]) same = 0;
			if (same) return pts_pkg::CLS_KW0 + 7'(i);
		end
		return pts_pkg::CLS_ID;
	endfunction

	// second of zero is a lone special
	function automatic logic [6:0] classify_op(logic [7:0] a, logic [7:0] b);
		for (int i = 0; i < pts_pkg::OpCount; i++) begin
			if (b == 8'h0 && operators[i].len() == 1 && operators[i][0] == a)
				return pts_pkg::CLS_OP0 + 7'(i);
			if (b != 8'h0 && operators[i].len() == 2 && operators[i][0] == a &&
				operators[i][1] == b)
				return pts_pkg::CLS_OP0 + 7'(i);
		end
		return pts_pkg::CLS_ID;
	endfunction

	function automatic void push_token(logic [6:0] c);
		token_t t;
		t.cls = c;
		t.lst = 1'b0;
		new_tokens.push_back(t);
	endfunction

	function automatic void begin_token(logic [7:0] c);
		p_mode = pts_pkg::MODE_IDLE;
		if (b_space(c)) return;
		if (b_alpha(c)) begin
			p_mode = pts_pkg::MODE_WORD;
			p_ovf = 1'b0;
			p_buf[0] = to_lower(c);
			p_len = 1;
		end else if (b_num(c)) begin
			p_mode = pts_pkg::MODE_INT;
		end else if (b_special(c)) begin
			p_mode = pts_pkg::MODE_SPECIAL;
			p_first = c;
		end else begin
			push_token(pts_pkg::CLS_ID);
		end
	endfunction

	// advance the predictor by one request and queue its tokens
	function automatic void predict_tokens(scan_req_t r);
		logic [7:0] c;
		c = r.ch;
		new_tokens.delete();
		if (r.cmd == pts_pkg::CMD_END) begin
			case (p_mode)
				pts_pkg::MODE_WORD: push_token(classify_word());
				pts_pkg::MODE_INT: push_token(pts_pkg::CLS_INT);
				pts_pkg::MODE_REAL: push_token(pts_pkg::CLS_REAL);
				pts_pkg::MODE_SPECIAL: push_token(classify_op(p_first, 8'h0));
				default: ;
			endcase
			push_token(pts_pkg::CLS_EOF);
			p_mode = pts_pkg::MODE_IDLE;
			p_len = 0;
			p_ovf = 1'b0;
		end else begin
			case (p_mode)
				pts_pkg::MODE_WORD: begin
					if (b_alpha(c) || b_num(c)) begin
						if (p_len < pts_pkg::MaxWord) begin
							p_buf[p_len] = to_lower(c);
							p_len++;
						end else p_ovf = 1'b1;
					end else begin
						push_token(classify_word());
						begin_token(c);
					end
				end
				pts_pkg::MODE_INT: begin
					if (c == 8'h2e) p_mode = pts_pkg::MODE_REAL;
					else if (!b_num(c)) begin
						push_token(pts_pkg::CLS_INT);
						begin_token(c);
					end
				end
				pts_pkg::MODE_REAL: begin
					if (!b_num(c)) begin
						push_token(pts_pkg::CLS_REAL);
						begin_token(c);
					end
				end
				pts_pkg::MODE_SPECIAL: begin
					if (b_special(c)) begin
						push_token(classify_op(p_first, c));
						p_mode = pts_pkg::MODE_IDLE;
					end else begin
						push_token(classify_op(p_first, 8'h0));
						begin_token(c);
					end
				end
				default: begin_token(c);
			endcase
		end
		if (new_tokens.size() > 0) new_tokens[new_tokens.size()-1].lst = 1'b1;
		foreach (new_tokens[i]) expected_tokens.push_back(new_tokens[i]);
	endfunction

	task automatic report_mismatch(string msg);
		$display("mismatch: %s", msg);
		error_count++;
	endtask

	function automatic void add_byte(logic [7:0] c);
		scan_req_t r;
		r.cmd = pts_pkg::CMD_BYTE;
		r.ch = c;
		pending_reqs.push_back(r);
	endfunction
	function automatic void add_end(logic [7:0] c);
		scan_req_t r;
		r.cmd = pts_pkg::CMD_END;
		r.ch = c;
		pending_reqs.push_back(r);
	endfunction
	function automatic void add_text(string s);
		for (int i = 0; i < s.len(); i++) add_byte(s[i]);
	endfunction

	function automatic logic [7:0] rand_letter();
		logic [7:0] c;
		c = 8'h61 + 8'($urandom_range(0, 25));
		return $urandom_range(0, 3) == 0 ? c - 8'd32 : c;
	endfunction

	// one random piece of source text, or a stray byte or end request, with random content
	function automatic void add_fragment();
		int n;
		string s;
		case ($urandom_range(0, 9))
			0, 1: begin
				s = keywords[$urandom_range(0, pts_pkg::KwCount-1)];
				for (int i = 0; i < s.len(); i++)
					add_byte($urandom_range(0, 2) == 0 ? s[i] - 8'd32 : s[i]);
			end
			2: begin
				n = $urandom_range(0, 3) == 0 ? $urandom_range(13, 18) : $urandom_range(1, 6);
				add_byte(rand_letter());
				for (int i = 1; i < n; i++)
					add_byte($urandom_range(0, 3) == 0 ? 8'h30 + 8'($urandom_range(0, 9))
						: rand_letter());
			end
			3: begin
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++) add_byte(8'h30 + 8'($urandom_range(0, 9)));
				if ($urandom_range(0, 1)) begin
					add_byte(8'h2e);
					n = $urandom_range(0, 3);
					for (int i = 0; i < n; i++) add_byte(8'h30 + 8'($urandom_range(0, 9)));
				end
			end
			4, 5: add_text(operators[$urandom_range(0, pts_pkg::OpCount-1)]);
			6: begin
				add_byte(specials[$urandom_range(0, specials.len()-1)]);
				add_byte(specials[$urandom_range(0, specials.len()-1)]);
			end
			7: add_byte(8'($urandom_range(0, 255)));
			8: add_end(8'($urandom_range(0, 255)));
			default: ;
		endcase
		// separator or none, so tokens also abut
		case ($urandom_range(0, 5))
			0: add_byte(8'h20);
			1: add_byte(8'h09);
			2: add_byte(8'h0a);
			3: add_byte(8'h20);
			default: ;
		endcase
	endfunction

	// stimulus
	initial begin
		stim_done = 1'b0;
		// directed: keywords, long word, numbers, operators, odd bytes
		add_text("BEGIN implementation x1 ");
		add_text("abcdefghijklmnopq 42 3.14.5 7. ");
		add_text(":=<>(**)+ :a <<");
		add_byte(8'h2e);
		add_byte(8'h0d);
		add_byte(8'hff);
		add_byte(8'h00);
		add_byte(8'h80);
		add_end(8'h7f);
		add_end(8'h00);
		add_text("x");
		add_end(8'hff);
		add_text("9");
		add_end(8'h55);
		add_text("1.");
		add_end(8'haa);
		add_text("^");
		add_end(8'h00);
		for (int i = 0; i < 200; i++) add_fragment();
		add_end(8'h00);
		// sender pauses until every expected token has come back
		wait (pending_reqs.size() == 0 && expected_tokens.size() == 0);
		for (int i = 0; i < 90; i++) add_fragment();
		add_end(8'h00);
		stim_done = 1'b1;
	end

	// request driver, bursts with gaps
	initial begin
		valid = 1'b0;
		command = pts_pkg::CMD_BYTE;
		text_byte = 8'h00;
	end
	int burst_left;
	int gap_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid <= 1'b0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (!valid || ready) begin
			if (valid) predict_tokens('{command, text_byte});
			if (valid && ready) void'(pending_reqs.pop_front());
			if (gap_left > 0) begin
				valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_reqs.size() > 0) begin
				valid <= 1'b1;
				command <= pending_reqs[0].cmd;
				text_byte <= pending_reqs[0].ch;
				if (burst_left == 0) begin
					burst_left <= $urandom_range(1, 40);
					gap_left <= $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
				end else burst_left <= burst_left - 1;
			end else begin
				valid <= 1'b0;
			end
		end
	end

	// receiver stall pattern, with one long hold-off
	initial out_ready = 1'b0;
	int stall_phase;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_phase <= 0;
			hold_off <= 0;
		end else begin
			stall_phase <= stall_phase + 1;
			if (stall_phase == 400) begin
				hold_off <= 60;
				out_ready <= 1'b0;
			end else if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				out_ready <= 1'b0;
			end else if ((stall_phase / 128) % 3 == 0) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= (stall_phase % 7) != 3 && $urandom_range(0, 3) != 0;
			end
		end
	end

	// result monitor
	token_t exp_tok;
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_tokens.size() == 0) begin
				report_mismatch($sformatf("unexpected class %0d", token_class));
			end else begin
				exp_tok = expected_tokens.pop_front();
				if (token_class !== exp_tok.cls)
					report_mismatch($sformatf("class %0d, expected %0d", token_class,
						exp_tok.cls));
				if (last !== exp_tok.lst)
					report_mismatch($sformatf("last %b, expected %b", last, exp_tok.lst));
			end
		end
	end

	// reset and end of run
	initial begin
		error_count = 0;
		p_mode = pts_pkg::MODE_IDLE;
		p_len = 0;
		p_ovf = 1'b0;
		p_first = 8'h00;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		wait (stim_done && pending_reqs.size() == 0 && !valid);
		wait (expected_tokens.size() == 0);
		repeat (20) @(posedge clk);
		if (error_count == 0 && expected_tokens.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
